[rtl/tcps_pkg.sv]
`timescale 1ns / 1ps

package tcps_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    // Register port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR = 1'b0;

    // Cell and character codes
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

    // Action codes
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RWAIT,
        ST_BLANK
    } ctl_state_t;

endpackage

[rtl/tcps_if.sv]
`timescale 1ns / 1ps

interface tcps_cmd_if;
    import tcps_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, action, char_code, cell_index, input ready);
    modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcps_res_if;
    import tcps_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [IDX_W-1:0]  cursor_cell;
    logic              scrolled;

    modport source (output valid, cell_char, cell_attr, cursor_cell, scrolled, input ready);
    modport sink   (input valid, cell_char, cell_attr, cursor_cell, scrolled, output ready);
endinterface

[rtl/tcps_ram.sv]
`timescale 1ns / 1ps

module tcps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tcps_regs.sv]
`timescale 1ns / 1ps

module tcps_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcps_pkg::PADDR_W-1:0] paddr,
    input  logic [tcps_pkg::PDATA_W-1:0] pwdata,
    output logic [tcps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [tcps_pkg::ATTR_W-1:0]  text_attr
);
    import tcps_pkg::*;

    logic [ATTR_W-1:0]    attr_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_attr;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_attr = psel && penable && pwrite && (reg_idx == REG_TEXT_ATTR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (wr_attr)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_TEXT_ATTR)
        begin
            prdata = {(PDATA_W-ATTR_W)'(0), attr_reg};
        end
    end

    assign pready    = 1'b1;
    assign text_attr = attr_reg;

endmodule

[rtl/text_console_putchar_scroll.sv]
`timescale 1ns / 1ps
// Text console: a COLUMNS x ROWS screen of 16-bit cells (char low, attr high)
// and a cursor.
// Channels: cmd (sink) takes one transaction per action: put char_code at the
// cursor (newline moves to the start of the next row) or read the cell at
// cell_index. res (source) returns exactly one transaction per command with
// the cell read (zero for a put), the cursor after the command and a scroll
// flag. The APB port holds text_attribute at byte address 0.
// Flow: in ST_EXEC a put writes its glyph (none for a newline) and registers
// its result, or a read issues the RAM read, registered in ST_RWAIT. A new
// command is taken in ST_IDLE; a scrolling put first blanks the freed row in
// ST_BLANK, one cell a cycle through the single write port of the screen RAM.
// Scrolling moves no data: the screen RAM is a ring of rows with a top-row
// offset, so a scroll bumps the offset and blanks the old top row.
// Reset: a clearing pass writes a blank cell to every RAM entry while
// cmd.ready stays low; APB writes are taken meanwhile.
// Stall: the result sits in an output register; a held res.ready stalls
// only the final step of the next command, never its acceptance.

module text_console_putchar_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    tcps_cmd_if.sink                     cmd,
    tcps_res_if.source                   res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcps_pkg::PADDR_W-1:0] paddr,
    input  logic [tcps_pkg::PDATA_W-1:0] pwdata,
    output logic [tcps_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import tcps_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(CELLS);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int AW    = ((CW > IDX_W) ? CW : IDX_W) + 1;

    // register block
    logic [ATTR_W-1:0] text_attr;

    tcps_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .text_attr (text_attr)
    );

    // control state
    ctl_state_t       state_reg, state_next;
    logic [CW-1:0]    cursor_reg, cursor_next;   // logical cursor cell
    logic [COLW-1:0]  col_reg, col_next;         // cursor column
    logic [CW-1:0]    top_reg, top_next;         // physical cell of row 0
    logic [CW-1:0]    addr_reg, addr_next;       // clear / blank address
    logic [COLW-1:0]  bcol_reg, bcol_next;       // blank cells done

    // latched command
    logic              act_reg, act_next;
    logic [CHAR_W-1:0] code_reg, code_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // output register
    logic              ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0] ochar_reg, ochar_next;
    logic [ATTR_W-1:0] oattr_reg, oattr_next;
    logic [IDX_W-1:0]  ocur_reg, ocur_next;
    logic              oscr_reg, oscr_next;

    // logical -> physical cell through the ring offset
    logic          idx_ok;
    logic [CW-1:0] log_addr;
    logic [CW:0]   phys_sum;
    logic [CW-1:0] phys_addr;

    assign idx_ok   = AW'(idx_reg) < AW'(CELLS);
    assign log_addr = (act_reg == ACT_READ) ? CW'(idx_reg) : cursor_reg;
    assign phys_sum = {1'b0, log_addr} + {1'b0, top_reg};
    assign phys_addr = (phys_sum >= (CW+1)'(CELLS)) ?
                       CW'(phys_sum - (CW+1)'(CELLS)) : phys_sum[CW-1:0];

    // RAM port
    logic              ram_we;
    logic [CW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CELL_W-1:0] ram_rdata;

    tcps_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (phys_addr),
        .rd_data (ram_rdata)
    );

    // cursor advance
    logic          is_nl;
    logic [CW:0]   cur_adv;
    logic [COLW-1:0] col_adv;
    logic          do_scroll;

    assign is_nl   = (code_reg == NEWLINE_CODE);
    assign cur_adv = is_nl ?
                     ({1'b0, cursor_reg} - (CW+1)'(col_reg) + (CW+1)'(COLUMNS)) :
                     ({1'b0, cursor_reg} + (CW+1)'(1));
    assign col_adv = (is_nl || col_reg == COLW'(COLUMNS - 1)) ? '0 : col_reg + COLW'(1);
    assign do_scroll = (cur_adv == (CW+1)'(CELLS));

    logic out_free;
    assign out_free = !ovalid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cursor_reg <= '0;
            col_reg    <= '0;
            top_reg    <= '0;
            addr_reg   <= '0;
            bcol_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            top_reg    <= top_next;
            addr_reg   <= addr_next;
            bcol_reg   <= bcol_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        code_reg  <= code_next;
        idx_reg   <= idx_next;
        ochar_reg <= ochar_next;
        oattr_reg <= oattr_next;
        ocur_reg  <= ocur_next;
        oscr_reg  <= oscr_next;
    end

    // Sequencer. One command at a time, so RAM reads never race a write.
    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        col_next    = col_reg;
        top_next    = top_reg;
        addr_next   = addr_reg;
        bcol_next   = bcol_reg;
        act_next    = act_reg;
        code_next   = code_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !res.ready;
        ochar_next  = ochar_reg;
        oattr_next  = oattr_reg;
        ocur_next   = ocur_reg;
        oscr_next   = oscr_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = BLANK_CELL;
        ram_re      = 1'b0;
        cmd.ready   = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == CW'(CELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + CW'(1);
                end
            end

            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    act_next   = cmd.action;
                    code_next  = cmd.char_code;
                    idx_next   = cmd.cell_index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (act_reg == ACT_READ)
                begin
                    ram_re     = idx_ok;
                    state_next = ST_RWAIT;
                end
                else if (out_free)
                begin
                    if (!is_nl)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = phys_addr;
                        ram_wdata = {text_attr, code_reg};
                    end
                    ovalid_next = 1'b1;
                    ochar_next  = '0;
                    oattr_next  = '0;
                    oscr_next   = do_scroll;
                    if (do_scroll)
                    begin
                        // old top row becomes the new, blank last row
                        cursor_next = CW'(CELLS - COLUMNS);
                        col_next    = '0;
                        top_next    = (top_reg == CW'(CELLS - COLUMNS)) ?
                                      '0 : top_reg + CW'(COLUMNS);
                        addr_next   = top_reg;
                        bcol_next   = '0;
                        ocur_next   = IDX_W'(CELLS - COLUMNS);
                        state_next  = ST_BLANK;
                    end
                    else
                    begin
                        cursor_next = cur_adv[CW-1:0];
                        col_next    = col_adv;
                        ocur_next   = IDX_W'(cur_adv[CW-1:0]);
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_RWAIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = idx_ok ? ram_rdata[CHAR_W-1:0] : '0;
                    oattr_next  = idx_ok ? ram_rdata[CELL_W-1:CHAR_W] : '0;
                    ocur_next   = IDX_W'(cursor_reg);
                    oscr_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end

            ST_BLANK:
            begin
                ram_we    = 1'b1;
                addr_next = addr_reg + CW'(1);
                bcol_next = bcol_reg + COLW'(1);
                if (bcol_reg == COLW'(COLUMNS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid       = ovalid_reg;
    assign res.cell_char   = ochar_reg;
    assign res.cell_attr   = oattr_reg;
    assign res.cursor_cell = ocur_reg;
    assign res.scrolled    = oscr_reg;

endmodule

[rtl/tcps_checker.sv]
`timescale 1ns / 1ps

module tcps_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [tcps_pkg::CHAR_W-1:0] res_cell_char,
    input logic [tcps_pkg::ATTR_W-1:0] res_cell_attr,
    input logic [tcps_pkg::IDX_W-1:0]  res_cursor_cell,
    input logic                        res_scrolled
);
    import tcps_pkg::*;

    localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(COLUMNS * ROWS - COLUMNS);

    // result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_cell_char) && $stable(res_cell_attr)
                                    && $stable(res_cursor_cell) && $stable(res_scrolled))
        else $error("result changed while stalled");

    // a scroll parks the cursor at the last row and reports no cell
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_scrolled |-> res_cursor_cell == LAST_ROW
                                      && res_cell_char == '0 && res_cell_attr == '0)
        else $error("bad scroll result");

    // one command in flight: no acceptance right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

endmodule

bind text_console_putchar_scroll tcps_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_cell_char   (res.cell_char),
    .res_cell_attr   (res.cell_attr),
    .res_cursor_cell (res.cursor_cell),
    .res_scrolled    (res.scrolled)
);

[verif/tb_text_console_putchar_scroll.sv]
`timescale 1ns / 1ps

module tb_text_console_putchar_scroll;
    import tcps_pkg::*;

    // Screen geometry; the DUT gets the same values so the model and RTL agree
    localparam int COLS           = 80;
    localparam int ROWS           = 25;
    localparam int CELLS          = COLS * ROWS;
    localparam int LAST_ROW_START = COLS * (ROWS - 1);
    localparam int MAX_INDEX      = (1 << IDX_W) - 1;

    // A scrolling put keeps blanking a row after its result is out, so every
    // quiet period waits at least that long before touching the register.
    localparam int SETTLE_CYCLES = COLS + 10;

    localparam logic [PADDR_W-1:0] ATTR_ADDR  = {REG_TEXT_ATTR, 2'b00};
    // Only other register index of the address; writes there must not land anywhere
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_TEXT_ATTR, 2'b00};

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [IDX_W-1:0]  cursor_cell;
        logic              scrolled;
    } console_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tcps_cmd_if cmd_ch ();
    tcps_res_if res_ch ();

    text_console_putchar_scroll #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Console model: screen image, cursor and attribute register as the
    // testbench believes them to be. Updated at command acceptance.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] screen_image [CELLS];
    int unsigned       cursor_now;
    logic [ATTR_W-1:0] attr_now;

    console_result_t expected_results [$];
    int              mismatches = 0;

    // Shared knobs: no_idle turns off random gaps on both channels,
    // hold_request asks the result sink to hold ready low, its value the hold length.
    bit no_idle      = 1'b0;
    int hold_request = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the DUT wedges
    initial begin
        #1_000_000;
        $display("tb_text_console_putchar_scroll: FAIL");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        if (mismatches < 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endfunction

    // Applies one command to the model and returns the response it should give.
    function automatic console_result_t predict_console(input logic act,
                                                        input logic [CHAR_W-1:0] code,
                                                        input logic [IDX_W-1:0] idx);
        console_result_t r;
        int unsigned     cur;
        r = '0;
        if (act == ACT_READ) begin
            // out-of-range reads return zeros and touch nothing
            if (idx < CELLS) begin
                r.cell_char = screen_image[idx][CHAR_W-1:0];
                r.cell_attr = screen_image[idx][CELL_W-1:CHAR_W];
            end
        end else begin
            cur = cursor_now;
            if (code == NEWLINE_CODE) begin
                cur = (cur / COLS + 1) * COLS;
            end else begin
                if (cur < CELLS)
                    screen_image[cur] = {attr_now, code};
                cur++;
            end
            // Ran off the end: shift everything up a row, blank the bottom
            if (cur >= CELLS) begin
                for (int i = 0; i < LAST_ROW_START; i++)
                    screen_image[i] = screen_image[i + COLS];
                for (int i = LAST_ROW_START; i < CELLS; i++)
                    screen_image[i] = BLANK_CELL;
                cur = LAST_ROW_START;
                r.scrolled = 1'b1;
            end
            cursor_now = cur;
        end
        r.cursor_cell = cursor_now[IDX_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side. All tasks are entered on a rising edge and drive with
    // NBAs; valid stays high across back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic act, input logic [CHAR_W-1:0] code,
                            input logic [IDX_W-1:0] idx);
        while (!no_idle && $urandom_range(0, 99) < 22) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= act;
        cmd_ch.char_code  <= code;
        cmd_ch.cell_index <= idx;
        do @(posedge clk); while (!cmd_ch.ready);
        expected_results.push_back(predict_console(act, code, idx));
    endtask

    // Unused payload fields get random values so their bits toggle too
    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_cmd(ACT_PUT, code, IDX_W'($urandom_range(0, MAX_INDEX)));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_cmd(ACT_READ, CHAR_W'($urandom), idx);
    endtask

    task automatic send_noise();
        send_cmd(1'($urandom), CHAR_W'($urandom), IDX_W'($urandom_range(0, MAX_INDEX)));
    endtask

    function automatic logic [CHAR_W-1:0] random_glyph();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom); while (c == NEWLINE_CODE);
        return c;
    endfunction

    // Reads lean toward the bottom rows, where recent text lives
    function automatic logic [IDX_W-1:0] random_read_index();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return IDX_W'($urandom_range(LAST_ROW_START - 2 * COLS, CELLS - 1));
        else if (pick < 90)
            return IDX_W'($urandom_range(0, CELLS - 1));
        return IDX_W'($urandom_range(CELLS, MAX_INDEX));
    endfunction

    // Drop valid, drain every outstanding result, then let any row blanking
    // finish before the caller touches the register.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB: setup then access, then an idle bus state so calls can chain.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [ATTR_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(PDATA_W - ATTR_W)'($urandom), data};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (addr == ATTR_ADDR)
            attr_now = data;
    endtask

    task automatic check_attr_reg();
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ATTR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== PDATA_W'(attr_now))
            note_mismatch($sformatf("text_attribute read exp %h act %h",
                                    PDATA_W'(attr_now), got));
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, plus long holds on request
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= no_idle || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // Every accepted result is matched against the oldest prediction
    always @(posedge clk) begin
        console_result_t got;
        console_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.cell_char   = res_ch.cell_char;
            got.cell_attr   = res_ch.cell_attr;
            got.cursor_cell = res_ch.cursor_cell;
            got.scrolled    = res_ch.scrolled;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing pending: char %h attr %h cur %0d scr %b",
                                        got.cell_char, got.cell_attr, got.cursor_cell,
                                        got.scrolled));
            end else begin
                want = expected_results.pop_front();
                if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
                    got.cursor_cell !== want.cursor_cell || got.scrolled !== want.scrolled)
                    note_mismatch($sformatf({"char exp %h act %h, attr exp %h act %h, ",
                                             "cursor exp %0d act %0d, scrolled exp %b act %b"},
                                            want.cell_char, got.cell_char,
                                            want.cell_attr, got.cell_attr,
                                            want.cursor_cell, got.cursor_cell,
                                            want.scrolled, got.scrolled));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Blank screen after the clearing pass, reset attribute, edges of the
    // index range including reads past the last cell.
    task automatic test_reset_state();
        check_attr_reg();
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(MAX_INDEX);
    endtask

    // Extreme glyph bytes with extreme attributes; a write to the spare
    // register index must leave the attribute alone.
    task automatic test_glyph_extremes();
        wait_idle();
        apb_write(ATTR_ADDR, 8'h00);
        check_attr_reg();
        put_char(8'h00);
        wait_idle();
        apb_write(ATTR_ADDR, 8'hFF);
        check_attr_reg();
        put_char(8'hFF);
        wait_idle();
        apb_write(SPARE_ADDR, 8'h33);
        check_attr_reg();
        put_char(8'h41);
        read_cell(0);
        read_cell(1);
        read_cell(2);
    endtask

    // Walk down with newlines, drop a glyph on the bottom row, then a
    // newline there scrolls it up one row and leaves a blank bottom row.
    task automatic test_newline_scroll();
        while (cursor_now < LAST_ROW_START)
            put_char(NEWLINE_CODE);
        put_char(8'h5A);
        put_char(NEWLINE_CODE);
        read_cell(LAST_ROW_START - COLS);
        read_cell(LAST_ROW_START);
    endtask

    // Gapless traffic on both channels
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (40) send_noise();
        no_idle = 1'b0;
    endtask

    // Result sink stalls for a long time while commands keep coming; the
    // output register and the in-flight command fill, then cmd.ready drops.
    task automatic test_output_stall();
        hold_request = 300;
        no_idle      = 1'b1;
        repeat (12) put_char(random_glyph());
        no_idle      = 1'b0;
    endtask

    // Mostly text: full rows (the last glyph of a bottom row scrolls), short
    // lines ended by newline, reads of recent cells, and some raw noise.
    // The attribute changes between phases; the last phase has no gaps.
    task automatic test_random_traffic();
        int                sent;
        int                kind;
        int                n;
        logic [ATTR_W-1:0] attr_pick;
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            attr_pick = (phase == 1) ? 8'h00 : (phase == 2) ? 8'hFF : ATTR_W'($urandom);
            apb_write(ATTR_ADDR, attr_pick);
            check_attr_reg();
            no_idle = (phase == 3);
            sent = 0;
            while (sent < 100) begin
                kind = (phase == 0 && sent == 0) ? 0 : $urandom_range(0, 99);
                if (kind < 30) begin
                    if (cursor_now % COLS != 0) begin
                        put_char(NEWLINE_CODE);
                        sent++;
                    end
                    repeat (COLS) put_char(random_glyph());
                    sent += COLS;
                end else if (kind < 65) begin
                    n = $urandom_range(1, 20);
                    repeat (n) put_char(random_glyph());
                    put_char(NEWLINE_CODE);
                    sent += n + 1;
                end else if (kind < 85) begin
                    n = $urandom_range(1, 8);
                    repeat (n) read_cell(random_read_index());
                    sent += n;
                end else begin
                    n = $urandom_range(1, 10);
                    repeat (n) send_noise();
                    sent += n;
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.action     <= ACT_PUT;
        cmd_ch.char_code  <= '0;
        cmd_ch.cell_index <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        for (int i = 0; i < CELLS; i++)
            screen_image[i] = BLANK_CELL;
        cursor_now = 0;
        attr_now   = ATTR_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The DUT clears its RAM after reset; the first send just waits on ready
        test_reset_state();
        test_glyph_extremes();
        test_newline_scroll();
        test_back_to_back();
        test_output_stall();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_text_console_putchar_scroll: PASS");
        else
            $display("tb_text_console_putchar_scroll: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/tcps_pkg.sv
rtl/tcps_if.sv
rtl/tcps_ram.sv
rtl/tcps_regs.sv
rtl/text_console_putchar_scroll.sv
rtl/tcps_checker.sv
verif/tb_text_console_putchar_scroll.sv
